### rtl/hwas_pkg.sv
// package for the heater warmup and arc sequencer
// request and result types, config set, mode codes and fixed heater codes
// no dependencies
package hwas_pkg;

    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int ARC_CNT_W   = 8;
    localparam int FLASH_W     = 6;
    localparam int CODE_W      = 16;
    localparam int MODE_W      = 2;
    localparam int COUNT_WIDTH_DEFAULT = 16;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_STARTUP  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WARMUP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READY    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 2'd3;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_DEFAULT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_RECOVERY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_SHORT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HV_ON_DELAY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_WINDOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ARC_WINDOW_MIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ARC_WINDOW_MAX  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ARCS_REPEATED   = 3'd7;

    // config reset values
    localparam logic [CFG_W-1:0]     RST_WARMUP_DEFAULT  = 16'd18000;
    localparam logic [CFG_W-1:0]     RST_WARMUP_RECOVERY = 16'd1000;
    localparam logic [CFG_W-1:0]     RST_WARMUP_SHORT    = 16'd6000;
    localparam logic [CFG_W-1:0]     RST_HV_ON_DELAY     = 16'd500;
    localparam logic [CFG_W-1:0]     RST_BACKOFF_WINDOW  = 16'd6000;
    localparam logic [CFG_W-1:0]     RST_ARC_WINDOW_MIN  = 16'd100;
    localparam logic [CFG_W-1:0]     RST_ARC_WINDOW_MAX  = 16'd200;
    localparam logic [ARC_CNT_W-1:0] RST_ARCS_REPEATED   = 8'd5;

    // heater dac codes
    localparam logic [CODE_W-1:0] DEFAULT_HEATER_CODE = 16'd6300;
    localparam logic [CODE_W-1:0] FAST_HEATER_CODE    = 16'd7000;
    localparam logic [CODE_W-1:0] BACKOFF_HEATER_CODE = 16'd5000;

    // led flash periods in ticks
    localparam logic [FLASH_W-1:0] FLASH_FIRST  = 6'd10;
    localparam logic [FLASH_W-1:0] FLASH_RELOAD = 6'd50;

    typedef struct packed {
        logic tick;
        logic pulse_edge;
        logic arc_edge;
        logic fault_assert;
        logic fault_clear;
        logic fast_heat;
        logic short_reset_n;
        logic heater_sum_fault;
        logic heater_overcurrent;
        logic heater_undercurrent;
    } t_req;

    typedef struct packed {
        logic [MODE_W-1:0] ctrl_state;
        logic              standby;
        logic              heater_enable_n;
        logic              hv_on;
        logic              grid_enable;
        logic              reset_detect;
        logic              heater_led;
        logic              arc_fault_strobe;
        logic [CODE_W-1:0] heater_code;
    } t_rsp;

    typedef struct packed {
        logic [CFG_W-1:0]     warmup_default_ticks;
        logic [CFG_W-1:0]     warmup_recovery_ticks;
        logic [CFG_W-1:0]     warmup_short_ticks;
        logic [CFG_W-1:0]     hv_on_delay_ticks;
        logic [CFG_W-1:0]     backoff_window_ticks;
        logic [CFG_W-1:0]     arc_window_min_ticks;
        logic [CFG_W-1:0]     arc_window_max_ticks;
        logic [ARC_CNT_W-1:0] arc_limit;
    } t_cfg;

endpackage

### rtl/heater_warmup_arc_sequencer_top.sv
// the result for a request is registered and shown in the cycle after it is accepted
// throughput: one request per cycle while the output side is ready; the sequencer state updates in the accept cycle
// a held result stalls input only when the output side is not ready to take it
// reset: synchronous, active low; mode startup, config registers at their defaults
// top level of the heater warmup and arc sequencer; depends on hwas_pkg, hwas_core
module heater_warmup_arc_sequencer_top
    import hwas_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_req                 i_in_data,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_rsp                 o_out_data,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // configuration register bank
    t_cfg r_cfg;

    // output stage: one result register with its valid flag
    logic r_out_valid;
    t_rsp r_out;
    t_rsp core_rsp;
    logic in_accept;

    // a new request may enter whenever the result register is empty or being drained
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // config writes land immediately; index decode is full over the 3-bit space
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warmup_default_ticks  <= RST_WARMUP_DEFAULT;
            r_cfg.warmup_recovery_ticks <= RST_WARMUP_RECOVERY;
            r_cfg.warmup_short_ticks    <= RST_WARMUP_SHORT;
            r_cfg.hv_on_delay_ticks     <= RST_HV_ON_DELAY;
            r_cfg.backoff_window_ticks  <= RST_BACKOFF_WINDOW;
            r_cfg.arc_window_min_ticks  <= RST_ARC_WINDOW_MIN;
            r_cfg.arc_window_max_ticks  <= RST_ARC_WINDOW_MAX;
            r_cfg.arc_limit             <= RST_ARCS_REPEATED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WARMUP_DEFAULT:  r_cfg.warmup_default_ticks  <= i_cfg_data;
                CFG_WARMUP_RECOVERY: r_cfg.warmup_recovery_ticks <= i_cfg_data;
                CFG_WARMUP_SHORT:    r_cfg.warmup_short_ticks    <= i_cfg_data;
                CFG_HV_ON_DELAY:     r_cfg.hv_on_delay_ticks     <= i_cfg_data;
                CFG_BACKOFF_WINDOW:  r_cfg.backoff_window_ticks  <= i_cfg_data;
                CFG_ARC_WINDOW_MIN:  r_cfg.arc_window_min_ticks  <= i_cfg_data;
                CFG_ARC_WINDOW_MAX:  r_cfg.arc_window_max_ticks  <= i_cfg_data;
                CFG_ARCS_REPEATED:   r_cfg.arc_limit             <= i_cfg_data[ARC_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer: state advances on each accepted request, result computed alongside
    hwas_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_accept),
        .i_req   (i_in_data),
        .i_cfg   (r_cfg),
        .o_rsp   (core_rsp)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= core_rsp;
        end
    end

`ifndef ASSERT_OFF
    // every accepted request produces a result in the next cycle
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted request produced no result");

    // shutdown results always show high voltage, grid and heater off
    a_shutdown_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.ctrl_state == MODE_SHUTDOWN))
            |-> (!o_out_data.hv_on && !o_out_data.grid_enable && o_out_data.heater_enable_n))
        else $error("shutdown result with hv, grid or heater on");

    // arc fault strobe only from ready, which a fault edge may leave in the same request
    a_strobe_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.arc_fault_strobe)
            |-> ((o_out_data.ctrl_state == MODE_READY)
                 || (o_out_data.ctrl_state == MODE_SHUTDOWN)))
        else $error("arc fault strobe outside ready");

    // standby is high exactly during warmup
    a_standby_warmup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.standby == (o_out_data.ctrl_state == MODE_WARMUP)))
        else $error("standby level does not match warmup mode");
`endif

endmodule

### rtl/hwas_core.sv
// sequencer state and next-state logic for the heater warmup and arc sequencer
// holds mode, counters and pin levels; gives the result for the request in flight
// depends on hwas_pkg
module hwas_core
    import hwas_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_step,
    input  t_req i_req,
    input  t_cfg i_cfg,
    output t_rsp o_rsp
);

    localparam int CW   = COUNT_WIDTH;
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

    logic [MODE_W-1:0]    r_mode,        n_mode;
    logic [CW-1:0]        r_warm_cnt,    n_warm_cnt;
    logic [FLASH_W-1:0]   r_flash_cnt,   n_flash_cnt;
    logic                 r_flash_lvl,   n_flash_lvl;
    logic [CW-1:0]        r_backoff_cnt, n_backoff_cnt;
    logic [ARC_CNT_W-1:0] r_arc_cnt,     n_arc_cnt;
    logic [CW-1:0]        r_arc_elapsed, n_arc_elapsed;
    logic [CODE_W-1:0]    r_heater,      n_heater;
    logic                 r_standby,     n_standby;
    logic                 r_heater_n,    n_heater_n;
    logic                 r_hv,          n_hv;
    logic                 r_grid,        n_grid;
    logic                 r_rst_det,     n_rst_det;
    logic                 strobe;
    logic                 htr_fault;

    // register values cut or widened to counter width
    logic [CW-1:0] ld_default, ld_recovery, ld_short, ld_backoff;

    assign ld_default  = CW'(i_cfg.warmup_default_ticks);
    assign ld_recovery = CW'(i_cfg.warmup_recovery_ticks);
    assign ld_short    = CW'(i_cfg.warmup_short_ticks);
    assign ld_backoff  = CW'(i_cfg.backoff_window_ticks);
    assign htr_fault   = i_req.heater_sum_fault | i_req.heater_overcurrent
                       | i_req.heater_undercurrent;

    always_comb begin
        n_mode        = r_mode;
        n_warm_cnt    = r_warm_cnt;
        n_flash_cnt   = r_flash_cnt;
        n_flash_lvl   = r_flash_lvl;
        n_backoff_cnt = r_backoff_cnt;
        n_arc_cnt     = r_arc_cnt;
        n_arc_elapsed = r_arc_elapsed;
        n_heater      = r_heater;
        n_standby     = r_standby;
        n_heater_n    = r_heater_n;
        n_hv          = r_hv;
        n_grid        = r_grid;
        n_rst_det     = r_rst_det;
        strobe        = 1'b0;

        unique case (r_mode)
            MODE_STARTUP: begin
                n_warm_cnt  = i_req.short_reset_n ? ld_default : ld_recovery;
                n_grid      = 1'b1;
                n_hv        = 1'b0;
                n_mode      = MODE_WARMUP;
                n_flash_cnt = FLASH_FIRST;
                n_standby   = 1'b1;
                n_heater_n  = 1'b0;
            end
            MODE_WARMUP: begin
                if (i_req.tick) begin
                    if (r_warm_cnt != '0) n_warm_cnt = r_warm_cnt - 1'b1;
                    if (r_flash_cnt != '0) n_flash_cnt = r_flash_cnt - 1'b1;
                end
                if (n_flash_cnt == '0) begin
                    n_flash_cnt = FLASH_RELOAD;
                    n_flash_lvl = ~r_flash_lvl;
                end
                // fast heat applies once per warmup
                if (i_req.fast_heat && (r_heater != FAST_HEATER_CODE)) begin
                    n_heater = FAST_HEATER_CODE;
                    if (n_warm_cnt > ld_short) n_warm_cnt = ld_short;
                end
                if (CMPW'(n_warm_cnt) <= CMPW'(i_cfg.hv_on_delay_ticks)) n_hv = 1'b1;
                if (i_req.fault_assert) begin
                    n_mode     = MODE_SHUTDOWN;
                    n_hv       = 1'b0;
                    n_heater_n = 1'b1;
                    n_grid     = 1'b0;
                    n_standby  = 1'b0;
                end else if (n_warm_cnt == '0) begin
                    n_heater      = DEFAULT_HEATER_CODE;
                    n_warm_cnt    = ld_default;
                    n_standby     = 1'b0;
                    n_rst_det     = 1'b1;
                    n_backoff_cnt = ld_backoff;
                    n_mode        = MODE_READY;
                end
            end
            MODE_READY: begin
                if (i_req.arc_edge && (r_arc_cnt != '1)) n_arc_cnt = r_arc_cnt + 1'b1;
                if (i_req.pulse_edge) begin
                    n_backoff_cnt = ld_backoff;
                    n_heater      = DEFAULT_HEATER_CODE;
                end
                if (i_req.tick) begin
                    if (n_backoff_cnt != '0) n_backoff_cnt = n_backoff_cnt - 1'b1;
                    if (n_backoff_cnt == '0) n_heater = BACKOFF_HEATER_CODE;
                    if (n_arc_cnt != '0) begin
                        if (r_arc_elapsed != '1) n_arc_elapsed = r_arc_elapsed + 1'b1;
                    end else begin
                        n_arc_elapsed = '0;
                    end
                end
                if (CMPW'(n_arc_elapsed) >= CMPW'(i_cfg.arc_window_min_ticks)) begin
                    if (n_arc_cnt >= i_cfg.arc_limit) strobe = 1'b1;
                    if (CMPW'(n_arc_elapsed) >= CMPW'(i_cfg.arc_window_max_ticks)) begin
                        n_arc_cnt = '0;
                    end
                end
                if (i_req.fault_assert) begin
                    n_mode     = MODE_SHUTDOWN;
                    n_hv       = 1'b0;
                    n_heater_n = 1'b1;
                    n_grid     = 1'b0;
                    n_standby  = 1'b0;
                end
            end
            default: begin
                // shutdown: voltage fault removal restarts warmup
                if (i_req.fault_clear) begin
                    n_grid      = 1'b1;
                    n_heater    = DEFAULT_HEATER_CODE;
                    n_mode      = MODE_WARMUP;
                    n_flash_cnt = FLASH_FIRST;
                    n_standby   = 1'b1;
                    n_heater_n  = 1'b0;
                end
            end
        endcase
    end

    always_comb begin
        o_rsp.ctrl_state       = n_mode;
        o_rsp.standby          = n_standby;
        o_rsp.heater_enable_n  = n_heater_n;
        o_rsp.hv_on            = n_hv;
        o_rsp.grid_enable      = n_grid;
        o_rsp.reset_detect     = n_rst_det;
        o_rsp.heater_led       = htr_fault | ((n_mode == MODE_WARMUP) & n_flash_lvl);
        o_rsp.arc_fault_strobe = strobe;
        o_rsp.heater_code      = n_heater;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_STARTUP;
            r_warm_cnt    <= '0;
            r_flash_cnt   <= FLASH_FIRST;
            r_flash_lvl   <= 1'b0;
            r_backoff_cnt <= CW'(RST_BACKOFF_WINDOW);
            r_arc_cnt     <= '0;
            r_arc_elapsed <= '0;
            r_heater      <= DEFAULT_HEATER_CODE;
            r_standby     <= 1'b0;
            r_heater_n    <= 1'b1;
            r_hv          <= 1'b0;
            r_grid        <= 1'b1;
            r_rst_det     <= 1'b0;
        end else if (i_step) begin
            r_mode        <= n_mode;
            r_warm_cnt    <= n_warm_cnt;
            r_flash_cnt   <= n_flash_cnt;
            r_flash_lvl   <= n_flash_lvl;
            r_backoff_cnt <= n_backoff_cnt;
            r_arc_cnt     <= n_arc_cnt;
            r_arc_elapsed <= n_arc_elapsed;
            r_heater      <= n_heater;
            r_standby     <= n_standby;
            r_heater_n    <= n_heater_n;
            r_hv          <= n_hv;
            r_grid        <= n_grid;
            r_rst_det     <= n_rst_det;
        end
    end

endmodule
